FILE: design/afsp_pkg.sv
// Shared types, constants and decode tables for the ADPCM FIFO sound player.
package afsp_pkg;

    localparam int FIFO_DEPTH = 1024;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH);
    localparam int HALF_FULL  = FIFO_DEPTH / 2;

    localparam int DIV_W  = 21;
    localparam int RATE_W = 14;
    localparam int PADDR_W = 4;

    localparam logic [DIV_W-1:0]  DIV_RESET  = 21'd1789772;
    localparam logic [RATE_W-1:0] SLOW_RESET = 14'd4000;
    localparam logic [RATE_W-1:0] FAST_RESET = 14'd8000;

    localparam logic [7:0]         STATUS_NOT_HALF = 8'h40;
    localparam logic [7:0]         STATUS_HALF     = 8'h00;
    localparam logic signed [11:0] PRED_RESET      = -12'sd2;
    localparam logic signed [11:0] PRED_MAX        = 12'sh7FF;
    localparam logic signed [11:0] PRED_MIN        = 12'sh800;
    localparam logic [5:0]         STEP_MAX        = 6'd48;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_DATA    = 2'd1,
        MODE_CONTROL = 2'd2,
        MODE_STATUS  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_CLOCK_DIVISOR = 2'd0,
        REG_SLOW_RATE     = 2'd1,
        REG_FAST_RATE     = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_DECODE  = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SRC_HELD = 2'd0,
        SRC_FIFO = 2'd1,
        SRC_ZERO = 2'd2
    } nib_src_t;

    typedef struct packed {
        logic [DIV_W-1:0]  clock_divisor;
        logic [RATE_W-1:0] slow_rate;
        logic [RATE_W-1:0] fast_rate;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] nibble;
        logic [7:0] status;
    } cmd_t;

    function automatic logic [10:0] step_size(input logic [5:0] idx);
        logic [10:0] s;
        case (idx)
            6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
            6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
            6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
            6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
            6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
            6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
            6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
            6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
            6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
            6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
            6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
            6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
            6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
            6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
            6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
            6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
            default: s = 11'd1552;
        endcase
        return s;
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

FILE: design/adpcm_fifo_sound_player.sv
// Top level of the ADPCM FIFO sound player: register port and front/queue/back.
// Takes one item (tick, data write, control write or status read) every clock and
// gives one result per item, registered through the front item register, the command
// queue and the output register; the sustained rate is one item per cycle, set by the
// predictor and step index update in the back end.
// Items stall only when the output is stalled long enough to fill the two-entry
// command queue. The byte FIFO is a single-port-write, registered-read memory of
// FIFO_DEPTH bytes with no clearing pass: only written entries are ever read.
module adpcm_fifo_sound_player (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic [7:0]                   data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [15:0]           sample,
    output logic [7:0]                   read_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afsp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import afsp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    reg_index_t reg_idx;
    logic       cfg_wr;

    logic       q_push;
    cmd_t       q_cmd_in;
    logic       q_full;
    logic       q_valid;
    cmd_t       q_cmd_out;
    logic       q_pop;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = 32'h0;
        case (reg_idx)
            REG_CLOCK_DIVISOR:
            begin
                prdata = 32'(cfg_reg.clock_divisor);
                if (cfg_wr)
                    cfg_next.clock_divisor = pwdata[DIV_W-1:0];
            end
            REG_SLOW_RATE:
            begin
                prdata = 32'(cfg_reg.slow_rate);
                if (cfg_wr)
                    cfg_next.slow_rate = pwdata[RATE_W-1:0];
            end
            REG_FAST_RATE:
            begin
                prdata = 32'(cfg_reg.fast_rate);
                if (cfg_wr)
                    cfg_next.fast_rate = pwdata[RATE_W-1:0];
            end
            default:
            begin
                prdata = 32'h0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_divisor <= DIV_RESET;
            cfg_reg.slow_rate     <= SLOW_RESET;
            cfg_reg.fast_rate     <= FAST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    afsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .data     (data),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd_in)
    );

    afsp_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .full    (q_full),
        .valid   (q_valid),
        .cmd_out (q_cmd_out),
        .pop     (q_pop)
    );

    afsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .read_data (read_data)
    );

endmodule

FILE: design/afsp_front.sv
// Front end: accepts items, owns the byte FIFO, phase accumulator and nibble fetch.
module afsp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    mode,
    input  logic [7:0]    data,
    input  afsp_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          q_push,
    output afsp_pkg::cmd_t q_cmd
);
    import afsp_pkg::*;

    logic [7:0] mem [FIFO_DEPTH];

    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] acc_reg, acc_next;
    logic             fast_reg, fast_next;
    logic             low_reg, low_next;
    logic [7:0]       held_reg;
    logic [7:0]       rdata_reg;

    logic             b_valid_reg, b_valid_next;
    cmd_kind_t        b_kind_reg, b_kind_next;
    nib_src_t         b_src_reg, b_src_next;
    logic [7:0]       b_status_reg, b_status_next;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [RATE_W-1:0] rate;
    logic [DIV_W:0]   sum;
    logic [DIV_W:0]   sum_sub;
    logic [3:0]       nibble;

    assign in_stall = b_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign q_push   = b_valid_reg & ~q_full;

    always_comb
    begin
        rptr_next     = rptr_reg;
        wptr_next     = wptr_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        fast_next     = fast_reg;
        low_next      = low_reg;
        b_kind_next   = CMD_NONE;
        b_src_next    = SRC_ZERO;
        b_status_next = STATUS_HALF;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rate          = fast_reg ? cfg.fast_rate : cfg.slow_rate;
        sum           = {1'b0, acc_reg} + (DIV_W+1)'(rate);
        sum_sub       = sum - {1'b0, cfg.clock_divisor};

        if (accept)
        begin
            case (mode_t'(mode))
                MODE_TICK:
                begin
                    if (sum >= {1'b0, cfg.clock_divisor})
                    begin
                        acc_next    = sum_sub[DIV_W-1:0];
                        b_kind_next = CMD_DECODE;
                        low_next    = ~low_reg;
                        if (low_reg)
                        begin
                            b_src_next = SRC_HELD;
                        end
                        else if (cnt_reg != '0)
                        begin
                            // pop the next byte, data lands in rdata_reg
                            b_src_next = SRC_FIFO;
                            rd_en      = 1'b1;
                            rptr_next  = (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                         : rptr_reg + 1'b1;
                            cnt_next   = cnt_reg - 1'b1;
                        end
                        else
                        begin
                            b_src_next = SRC_ZERO;
                        end
                    end
                    else
                    begin
                        acc_next = sum[DIV_W-1:0];
                    end
                end
                MODE_DATA:
                begin
                    // drop the byte when the FIFO already holds FIFO_DEPTH - 1 bytes
                    if (cnt_reg != CNT_W'(FIFO_DEPTH - 1))
                    begin
                        wr_en     = 1'b1;
                        wptr_next = (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                    : wptr_reg + 1'b1;
                        cnt_next  = cnt_reg + 1'b1;
                    end
                end
                MODE_CONTROL:
                begin
                    fast_next   = data[6];
                    rptr_next   = '0;
                    wptr_next   = '0;
                    cnt_next    = '0;
                    b_kind_next = CMD_RESTART;
                end
                MODE_STATUS:
                begin
                    b_status_next = (cnt_reg >= CNT_W'(HALF_FULL)) ? STATUS_HALF
                                    : STATUS_NOT_HALF;
                end
                default:
                begin
                    b_kind_next = CMD_NONE;
                end
            endcase
        end

        if (accept)
            b_valid_next = 1'b1;
        else if (q_push)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wptr_reg] <= data;
        if (rd_en)
            rdata_reg <= mem[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg     <= '0;
            wptr_reg     <= '0;
            cnt_reg      <= '0;
            acc_reg      <= '0;
            fast_reg     <= 1'b0;
            low_reg      <= 1'b0;
            held_reg     <= 8'h00;
            b_valid_reg  <= 1'b0;
            b_kind_reg   <= CMD_NONE;
            b_src_reg    <= SRC_ZERO;
            b_status_reg <= STATUS_HALF;
        end
        else
        begin
            rptr_reg    <= rptr_next;
            wptr_reg    <= wptr_next;
            cnt_reg     <= cnt_next;
            acc_reg     <= acc_next;
            fast_reg    <= fast_next;
            low_reg     <= low_next;
            b_valid_reg <= b_valid_next;
            if (accept)
            begin
                b_kind_reg   <= b_kind_next;
                b_src_reg    <= b_src_next;
                b_status_reg <= b_status_next;
            end
            // latch the popped byte (or zero when the FIFO was empty) as the item leaves, so the low nibble sees it
            if (q_push && b_kind_reg == CMD_DECODE)
            begin
                if (b_src_reg == SRC_FIFO)
                    held_reg <= rdata_reg;
                else if (b_src_reg == SRC_ZERO)
                    held_reg <= 8'h00;
            end
        end
    end

    always_comb
    begin
        case (b_src_reg)
            SRC_HELD: nibble = held_reg[3:0];
            SRC_FIFO: nibble = rdata_reg[7:4];
            default:  nibble = 4'h0;
        endcase
        q_cmd.kind   = b_kind_reg;
        q_cmd.nibble = nibble;
        q_cmd.status = b_status_reg;
    end

endmodule

FILE: design/afsp_cmd_queue.sv
// Two-entry command queue between the front and back ends.
module afsp_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  afsp_pkg::cmd_t cmd_in,
    output logic           full,
    output logic           valid,
    output afsp_pkg::cmd_t cmd_out,
    input  logic           pop
);
    import afsp_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign cmd_out = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: design/afsp_back.sv
// Back end: ADPCM nibble decode, predictor and step index, output register.
module afsp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  afsp_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] sample,
    output logic [7:0]         read_data
);
    import afsp_pkg::*;

    logic signed [11:0] pred_reg, pred_next;
    logic [5:0]         idx_reg, idx_next;
    logic signed [15:0] osamp_reg, osamp_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] sample_reg;
    logic [7:0]         read_data_reg;

    logic [10:0]        ss;
    logic [11:0]        diff;
    logic signed [13:0] pred_ext;
    logic signed [13:0] pred_sum;
    logic signed [11:0] pred_sat;
    logic signed [6:0]  idx_sum;
    logic [5:0]         idx_clamp;
    logic               load;

    assign load      = ~out_valid_reg | ~out_stall;
    assign q_pop     = q_valid & load;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign read_data = read_data_reg;

    always_comb
    begin
        ss   = step_size(idx_reg);
        diff = 12'(ss[10:3])
             + (q_cmd.nibble[2] ? 12'(ss) : 12'd0)
             + (q_cmd.nibble[1] ? 12'(ss[10:1]) : 12'd0)
             + (q_cmd.nibble[0] ? 12'(ss[10:2]) : 12'd0);
        pred_ext = {{2{pred_reg[11]}}, pred_reg};
        pred_sum = q_cmd.nibble[3] ? pred_ext - $signed({2'b00, diff})
                                   : pred_ext + $signed({2'b00, diff});
        if (pred_sum > 14'sd2047)
            pred_sat = PRED_MAX;
        else if (pred_sum < -14'sd2048)
            pred_sat = PRED_MIN;
        else
            pred_sat = pred_sum[11:0];

        idx_sum = $signed({1'b0, idx_reg}) + 7'(index_adjust(q_cmd.nibble[2:0]));
        if (idx_sum < 7'sd0)
            idx_clamp = 6'd0;
        else if (idx_sum > $signed({1'b0, STEP_MAX}))
            idx_clamp = STEP_MAX;
        else
            idx_clamp = idx_sum[5:0];

        pred_next  = pred_reg;
        idx_next   = idx_reg;
        osamp_next = osamp_reg;
        if (q_pop)
        begin
            case (q_cmd.kind)
                CMD_DECODE:
                begin
                    pred_next  = pred_sat;
                    idx_next   = idx_clamp;
                    osamp_next = {pred_sat, 4'h0};
                end
                CMD_RESTART:
                begin
                    pred_next = PRED_RESET;
                    idx_next  = 6'd0;
                end
                default:
                begin
                    pred_next = pred_reg;
                end
            endcase
        end

        if (q_pop)
            out_valid_next = 1'b1;
        else if (~out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sample_reg    <= osamp_next;
            read_data_reg <= q_cmd.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg      <= PRED_RESET;
            idx_reg       <= 6'd0;
            osamp_reg     <= 16'sd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_reg      <= pred_next;
            idx_reg       <= idx_next;
            osamp_reg     <= osamp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
